@@ src/qwfc_pkg.sv @@
// Package: formats, CORDIC angle table and register map for the flight control core.
`default_nettype none
package qwfc_pkg;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int CORDIC_ITER_DEF = 16;
  localparam int CORDIC_MAX      = 24;
  localparam int ANG_W           = 36;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] YAW_NEAR_Q30 = 36'sd214748365;

  typedef enum logic [2:0] {
    REG_TARGET_X   = 3'd0,
    REG_TARGET_Y   = 3'd1,
    REG_TARGET_ALT = 3'd2,
    REG_HOVER      = 3'd3,
    REG_ROLL_GAIN  = 3'd4,
    REG_PITCH_GAIN = 3'd5,
    REG_YAW_GAIN   = 3'd6,
    REG_VERT_GAIN  = 3'd7
  } reg_idx_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      default: r = 36'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ src/quadrotor_waypoint_flight_control_core.sv @@
// Top level: pipelined waypoint attitude controller with motor mixing.
//  channel | ports                        | transfer
//  input   | start/busy, in_*             | start && !busy
//  result  | out_valid, out_*             | out_valid (one cycle)
//  config  | APB psel..pready, 32-bit     | psel && penable && pwrite
// One sample per cycle; the result passes through the CORDIC stage chain (one
// iteration per stage) plus three front stages and three back stages. Reset clears
// valid bits and sets the configuration registers to defaults; data registers are
// not reset. busy is tied low; the receiver cannot stall.
`default_nettype none
module quadrotor_waypoint_flight_control_core #(
  parameter int CORDIC_ITERATIONS = qwfc_pkg::CORDIC_ITER_DEF,
  parameter int FRAC_BITS         = qwfc_pkg::FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [4:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                start,
  output logic               busy,
  input  wire  signed [14:0] in_roll_angle,
  input  wire  signed [14:0] in_pitch_angle,
  input  wire  signed [14:0] in_heading,
  input  wire  signed [23:0] in_pos_x,
  input  wire  signed [23:0] in_pos_y,
  input  wire  signed [23:0] in_altitude,
  input  wire  signed [15:0] in_roll_rate,
  input  wire  signed [15:0] in_pitch_rate,
  output logic               out_valid,
  output logic signed [23:0] out_front_left_speed,
  output logic signed [23:0] out_front_right_speed,
  output logic signed [23:0] out_rear_left_speed,
  output logic signed [23:0] out_rear_right_speed,
  output logic               out_at_target
);
  import qwfc_pkg::*;

  localparam int NI = (CORDIC_ITERATIONS < CORDIC_MAX) ? CORDIC_ITERATIONS : CORDIC_MAX;
  localparam int CW = 48;
  localparam int D2W = 52;
  localparam logic [D2W-1:0] THRESH =
    D2W'(((64'd1 << (2*FRAC_BITS)) * 64'd4 + 64'd50) / 64'd100);
  localparam logic signed [27:0] ALT_OFF = 28'(((64'sd6 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
  localparam logic signed [23:0] ONE = 24'sd1 <<< FRAC_BITS;
  localparam int YSH = 30 - FRAC_BITS;

  // configuration
  logic signed [23:0] tx_r, ty_r, talt_r;
  logic [15:0] hover_r, kr_r, kp_r, ky_r, kv_r;
  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0; ty_r <= '0; talt_r <= 24'sd4096;
      hover_r <= 16'd17536; kr_r <= 16'd12800; kp_r <= 16'd7680;
      ky_r <= 16'd384; kv_r <= 16'd768;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(ridx))
        REG_TARGET_X:   tx_r <= pwdata[23:0];
        REG_TARGET_Y:   ty_r <= pwdata[23:0];
        REG_TARGET_ALT: talt_r <= pwdata[23:0];
        REG_HOVER:      hover_r <= pwdata[15:0];
        REG_ROLL_GAIN:  kr_r <= pwdata[15:0];
        REG_PITCH_GAIN: kp_r <= pwdata[15:0];
        REG_YAW_GAIN:   ky_r <= pwdata[15:0];
        REG_VERT_GAIN:  kv_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(ridx))
      REG_TARGET_X:   prdata = {{8{tx_r[23]}}, tx_r};
      REG_TARGET_Y:   prdata = {{8{ty_r[23]}}, ty_r};
      REG_TARGET_ALT: prdata = {{8{talt_r[23]}}, talt_r};
      REG_HOVER:      prdata = {16'd0, hover_r};
      REG_ROLL_GAIN:  prdata = {16'd0, kr_r};
      REG_PITCH_GAIN: prdata = {16'd0, kp_r};
      REG_YAW_GAIN:   prdata = {16'd0, ky_r};
      REG_VERT_GAIN:  prdata = {16'd0, kv_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------- stage 1: differences, clamps, altitude error
  logic                v1_r;
  logic signed [24:0]  dx1_r, dy1_r;
  logic signed [14:0]  yaw1_r;
  logic signed [16:0]  roll_c1_r, pitch_c1_r, rrate1_r, prate1_r;
  logic signed [24:0]  e1_r;
  logic signed [27:0]  ealt;
  logic signed [16:0]  rc, pc;
  logic signed [24:0]  ec;

  always_comb begin
    ealt = 28'(talt_r) - 28'(in_altitude) + ALT_OFF;
    if (ealt > 28'(ONE)) ec = 25'(ONE);
    else if (ealt < -28'(ONE)) ec = -25'(ONE);
    else ec = 25'(ealt);
    if (17'(in_roll_angle) > 17'(ONE)) rc = 17'(ONE);
    else if (17'(in_roll_angle) < -17'(ONE)) rc = -17'(ONE);
    else rc = 17'(in_roll_angle);
    if (17'(in_pitch_angle) > 17'(ONE)) pc = 17'(ONE);
    else if (17'(in_pitch_angle) < -17'(ONE)) pc = -17'(ONE);
    else pc = 17'(in_pitch_angle);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    dx1_r <= 25'(tx_r) - 25'(in_pos_x);
    dy1_r <= 25'(ty_r) - 25'(in_pos_y);
    yaw1_r <= in_heading;
    roll_c1_r <= rc; pitch_c1_r <= pc;
    rrate1_r <= 17'(in_roll_rate); prate1_r <= 17'(in_pitch_rate);
    e1_r <= ec;
  end

  // ---------------- stage 2: squares, gain products, e^2, CORDIC pre-rotation
  logic                v2_r;
  logic signed [49:0]  sqx2_r, sqy2_r;
  logic signed [CW-1:0] cx2_r, cy2_r;
  logic signed [ANG_W-1:0] cz2_r;
  logic signed [14:0]  yaw2_r;
  logic signed [34:0]  rprod2_r, pprod2_r;
  logic signed [16:0]  rrate2_r, prate2_r;
  logic signed [49:0]  esq2_r;
  logic signed [24:0]  e2_r;
  logic signed [CW-1:0] xs0, ys0;

  always_comb begin
    xs0 = CW'(dx1_r) <<< 16;
    ys0 = CW'(dy1_r) <<< 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    sqx2_r <= 50'(dx1_r) * 50'(dx1_r);
    sqy2_r <= 50'(dy1_r) * 50'(dy1_r);
    if (dx1_r < 0) begin
      cz2_r <= (dy1_r >= 0) ? PI_Q30 : -PI_Q30;
      cx2_r <= -xs0; cy2_r <= -ys0;
    end else begin
      cz2_r <= '0;
      cx2_r <= xs0; cy2_r <= ys0;
    end
    yaw2_r <= yaw1_r;
    rprod2_r <= 35'(roll_c1_r) * 35'($signed({1'b0, kr_r}));
    pprod2_r <= 35'(pitch_c1_r) * 35'($signed({1'b0, kp_r}));
    rrate2_r <= rrate1_r; prate2_r <= prate1_r;
    esq2_r <= 50'(e1_r) * 50'(e1_r);
    e2_r <= e1_r;
  end

  // ---------------- CORDIC chain, one iteration per stage, side data delayed
  logic                    cv_r  [NI+1];
  logic signed [CW-1:0]    cx_r  [NI+1];
  logic signed [CW-1:0]    cy_r  [NI+1];
  logic signed [ANG_W-1:0] cz_r  [NI+1];
  logic                    far_r [NI+1];
  logic signed [14:0]      cyaw_r[NI+1];
  logic signed [23:0]      rin_r [NI+1];
  logic signed [23:0]      pin_r [NI+1];
  logic signed [23:0]      cube_r[NI+1];

  // stage 3 fills index 0: distance compare, roll/pitch terms, cube
  logic signed [50:0] d2s;
  logic signed [74:0] e3;
  always_comb begin
    d2s = 51'(sqx2_r) + 51'(sqy2_r);
    e3 = 75'(esq2_r) * 75'(e2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else cv_r[0] <= v2_r;
    cx_r[0] <= cx2_r; cy_r[0] <= cy2_r; cz_r[0] <= cz2_r;
    far_r[0] <= d2s > 51'(THRESH);
    cyaw_r[0] <= yaw2_r;
    rin_r[0] <= 24'((rprod2_r + 35'sd128) >>> 8) + 24'(rrate2_r);
    pin_r[0] <= 24'((pprod2_r + 35'sd128) >>> 8) + 24'(prate2_r);
    cube_r[0] <= 24'((e3 + (75'sd1 <<< (2*FRAC_BITS-1))) >>> (2*FRAC_BITS));
  end

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    logic signed [CW-1:0] xsh, ysh;
    assign xsh = cx_r[i] >>> i;
    assign ysh = cy_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else cv_r[i+1] <= cv_r[i];
      if (cy_r[i] > 0) begin
        cx_r[i+1] <= cx_r[i] + ysh;
        cy_r[i+1] <= cy_r[i] - xsh;
        cz_r[i+1] <= cz_r[i] + atan_q30(i);
      end else begin
        cx_r[i+1] <= cx_r[i] - ysh;
        cy_r[i+1] <= cy_r[i] + xsh;
        cz_r[i+1] <= cz_r[i] - atan_q30(i);
      end
      far_r[i+1] <= far_r[i];
      cyaw_r[i+1] <= cyaw_r[i];
      rin_r[i+1] <= rin_r[i];
      pin_r[i+1] <= pin_r[i];
      cube_r[i+1] <= cube_r[i];
    end
  end

  // ---------------- stage A: yaw error wrap, vertical product
  logic                    va_r, fara_r, neara_r;
  logic signed [ANG_W-1:0] diffa_r;
  logic signed [23:0]      rina_r, pina_r;
  logic signed [41:0]      vprod_r;
  logic signed [ANG_W:0]   dr;
  logic signed [ANG_W-1:0] dw;

  always_comb begin
    dr = (ANG_W+1)'(cz_r[NI]) - ((ANG_W+1)'(cyaw_r[NI]) <<< YSH);
    if (dr > (ANG_W+1)'(PI_Q30)) dw = ANG_W'(dr - (ANG_W+1)'(TWO_PI_Q30));
    else if (dr < -(ANG_W+1)'(PI_Q30)) dw = ANG_W'(dr + (ANG_W+1)'(TWO_PI_Q30));
    else dw = ANG_W'(dr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= cv_r[NI];
    fara_r <= far_r[NI];
    diffa_r <= dw;
    neara_r <= (dw < YAW_NEAR_Q30) && (dw > -YAW_NEAR_Q30);
    rina_r <= rin_r[NI];
    pina_r <= pin_r[NI];
    vprod_r <= 42'(cube_r[NI]) * 42'($signed({1'b0, kv_r}));
  end

  // ---------------- stage B: yaw product, base
  logic                vb_r, farb_r;
  logic signed [41:0]  yprod_r;
  logic signed [23:0]  rinb_r, pinb_r;
  logic signed [27:0]  baseb_r;
  logic signed [ANG_W-1:0] dsc;
  assign dsc = (diffa_r + (ANG_W'(1) <<< (YSH-1))) >>> YSH;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else vb_r <= va_r;
    farb_r <= fara_r;
    yprod_r <= fara_r ? 42'(dsc) * 42'($signed({1'b0, ky_r})) : '0;
    rinb_r <= rina_r;
    pinb_r <= pina_r + ((fara_r && neara_r) ? -(24'sd2 <<< FRAC_BITS) : 24'sd0);
    baseb_r <= (28'($signed({1'b0, hover_r})) <<< (FRAC_BITS-8))
             + 28'((vprod_r + 42'sd128) >>> 8);
  end

  // ---------------- stage C: mix and saturate
  logic signed [29:0] yin, m0, m1, m2, m3;
  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    if (v > 30'sd8388607) return 24'sh7FFFFF;
    else if (v < -30'sd8388608) return 24'sh800000;
    else return 24'(v);
  endfunction

  always_comb begin
    yin = 30'((yprod_r + 42'sd128) >>> 8);
    m0 = 30'(baseb_r) - 30'(rinb_r) + 30'(pinb_r) - yin;
    m1 = -(30'(baseb_r) + 30'(rinb_r) + 30'(pinb_r) + yin);
    m2 = -(30'(baseb_r) - 30'(rinb_r) - 30'(pinb_r) + yin);
    m3 = 30'(baseb_r) + 30'(rinb_r) - 30'(pinb_r) - yin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vb_r;
    out_front_left_speed  <= sat24(m0);
    out_front_right_speed <= sat24(m1);
    out_rear_left_speed   <= sat24(m2);
    out_rear_right_speed  <= sat24(m3);
    out_at_target <= !farb_r;
  end

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r[NI] |-> ##3 out_valid) else $error("result lost");
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vb_r)) else $error("result invented");
  a_near_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && !farb_r |-> yprod_r == 0) else $error("yaw term at target");
endmodule
`default_nettype wire
